FILE: design/sdd_pkg.sv
// shared types, constants and helpers for the speed display driver
`timescale 1ns / 1ps

package sdd_pkg;

  // speed limits and field widths
  localparam int unsigned SpeedW   = 14;
  localparam logic [13:0] SpeedMax = 14'd9999;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned CfgW     = 20;
  localparam int unsigned CfgIdxW  = 2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BLINK_ON     = 2'd0,
    CFG_BLINK_PERIOD = 2'd1,
    CFG_SCREEN_TO    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  // configuration reset values
  localparam logic [15:0] BlinkOnRst     = 16'd800;
  localparam logic [15:0] BlinkPeriodRst = 16'd1000;
  localparam logic [19:0] ScreenToRst    = 20'd300000;

  // ramp modes of the shown speed
  typedef enum logic [1:0] {
    RAMP_UNDECIDED = 2'd0,
    RAMP_RISING    = 2'd1,
    RAMP_FALLING   = 2'd2,
    RAMP_HOLDING   = 2'd3
  } ramp_mode_e;

  // digit enables
  localparam logic [7:0] DigThousands = 8'h80;
  localparam logic [7:0] DigHundreds  = 8'h40;
  localparam logic [7:0] DigTens      = 8'h20;
  localparam logic [7:0] DigUnits     = 8'h10;
  localparam logic [7:0] DigNone      = 8'h00;

  // slot codes of the multiplex counter
  localparam logic [2:0] SlotThousands = 3'd1;
  localparam logic [2:0] SlotHundreds  = 3'd2;
  localparam logic [2:0] SlotTens      = 3'd3;
  localparam logic [2:0] SlotUnits     = 3'd4;
  localparam logic [2:0] SlotIdle      = 3'd0;

  // timer flags after the timers of one transaction
  typedef struct packed {
    logic blink_dark;
    logic screen_off;
  } timer_status_t;

  // display slot result
  typedef struct packed {
    logic [7:0] segments;
    logic       segments_written;
    logic [7:0] digit_select;
    logic       latch;
  } slot_result_t;

  // clamp a raw speed field to the display range
  function automatic logic [13:0] sat_speed(input logic [13:0] v);
    sat_speed = (v > SpeedMax) ? SpeedMax : v;
  endfunction

  // seven-segment pattern, bit7 is segment a
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    unique case (digit)
      4'd0:    seg_pattern = 8'hFC;
      4'd1:    seg_pattern = 8'h60;
      4'd2:    seg_pattern = 8'hDA;
      4'd3:    seg_pattern = 8'hF2;
      4'd4:    seg_pattern = 8'h66;
      4'd5:    seg_pattern = 8'hB6;
      4'd6:    seg_pattern = 8'hBE;
      4'd7:    seg_pattern = 8'hE0;
      4'd8:    seg_pattern = 8'hFE;
      4'd9:    seg_pattern = 8'hF6;
      default: seg_pattern = 8'h00;
    endcase
  endfunction

endpackage

FILE: design/sdd_timers.sv
// blink timer and idle screen-off timer
`timescale 1ns / 1ps

module sdd_timers (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  tick_i,
  input  logic [9:0]            elapsed_i,
  input  logic                  run_i,
  input  logic                  knob_i,
  input  logic [15:0]           blink_on_i,
  input  logic [15:0]           blink_period_i,
  input  logic [19:0]           screen_to_i,
  output sdd_pkg::timer_status_t status_o
);

  logic [15:0] blink_timer_q, blink_timer_d;
  logic        blink_flag_q, blink_flag_d;
  logic [19:0] idle_timer_q, idle_timer_d;
  logic        off_flag_q, off_flag_d;
  logic [16:0] blink_sum;
  logic [15:0] blink_sat;
  logic [20:0] idle_sum;

  assign blink_sum = 17'(blink_timer_q) + 17'(elapsed_i);
  assign blink_sat = blink_sum[16] ? 16'hFFFF : blink_sum[15:0];
  assign idle_sum  = 21'(idle_timer_q) + 21'(elapsed_i);

  always_comb begin
    blink_timer_d = blink_timer_q;
    blink_flag_d  = blink_flag_q;
    idle_timer_d  = idle_timer_q;
    off_flag_d    = off_flag_q;
    if (tick_i) begin
      if (run_i && !knob_i) begin
        // lit phase, dark phase, then restart with the flag kept
        if (blink_sat <= blink_on_i) begin
          blink_timer_d = blink_sat;
          blink_flag_d  = 1'b0;
        end else if (blink_sat <= blink_period_i) begin
          blink_timer_d = blink_sat;
          blink_flag_d  = 1'b1;
        end else begin
          blink_timer_d = '0;
        end
      end else begin
        blink_timer_d = '0;
        blink_flag_d  = 1'b0;
      end
      if (knob_i || run_i) begin
        idle_timer_d = '0;
        off_flag_d   = 1'b0;
      end else if (idle_sum > 21'(screen_to_i)) begin
        idle_timer_d = screen_to_i;
        off_flag_d   = 1'b1;
      end else begin
        idle_timer_d = idle_sum[19:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_timer_q <= '0;
      blink_flag_q  <= 1'b0;
      idle_timer_q  <= '0;
      off_flag_q    <= 1'b0;
    end else if (en_i) begin
      blink_timer_q <= blink_timer_d;
      blink_flag_q  <= blink_flag_d;
      idle_timer_q  <= idle_timer_d;
      off_flag_q    <= off_flag_d;
    end
  end

  assign status_o.blink_dark = blink_flag_d;
  assign status_o.screen_off = off_flag_d;

endmodule

FILE: design/sdd_speed.sv
// shown speed selection and one-step ramp toward the control speed
`timescale 1ns / 1ps

module sdd_speed (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        refresh_i,
  input  logic        run_i,
  input  logic        knob_i,
  input  logic        stop_i,
  input  logic        ramp_reset_i,
  input  logic [13:0] set_speed_i,
  input  logic [13:0] actual_speed_i,
  input  logic [13:0] control_speed_i,
  output logic [13:0] speed_o
);

  logic [13:0]         speed_q, speed_d;
  sdd_pkg::ramp_mode_e mode_q, mode_d;
  logic [13:0]         setv, rel, ctl;

  assign setv = sdd_pkg::sat_speed(set_speed_i);
  assign rel  = sdd_pkg::sat_speed(actual_speed_i);
  assign ctl  = sdd_pkg::sat_speed(control_speed_i);

  always_comb begin
    speed_d = speed_q;
    mode_d  = ramp_reset_i ? sdd_pkg::RAMP_UNDECIDED : mode_q;
    if (refresh_i) begin
      if (!run_i || knob_i) begin
        speed_d = setv;
      end else if (stop_i) begin
        // coasting down toward the measured speed
        if (speed_q > rel) begin
          speed_d = speed_q - 14'd1;
        end
      end else begin
        // pick a direction from the measured speed first
        if (mode_d == sdd_pkg::RAMP_UNDECIDED) begin
          if (rel < ctl) begin
            mode_d  = sdd_pkg::RAMP_RISING;
            speed_d = rel;
          end else if (rel > ctl) begin
            mode_d  = sdd_pkg::RAMP_FALLING;
            speed_d = rel;
          end
        end
        unique case (mode_d)
          sdd_pkg::RAMP_RISING: begin
            if (speed_d < rel && speed_d < ctl) begin
              speed_d = speed_d + 14'd1;
            end
            if (speed_d >= ctl) begin
              mode_d = sdd_pkg::RAMP_HOLDING;
            end
          end
          sdd_pkg::RAMP_FALLING: begin
            if (speed_d > rel && speed_d > ctl) begin
              speed_d = speed_d - 14'd1;
            end else if (speed_d <= ctl) begin
              mode_d = sdd_pkg::RAMP_HOLDING;
            end
          end
          sdd_pkg::RAMP_HOLDING: begin
            speed_d = ctl;
          end
          default: begin
            speed_d = speed_d;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      mode_q  <= sdd_pkg::RAMP_UNDECIDED;
    end else if (en_i) begin
      speed_q <= speed_d;
      mode_q  <= mode_d;
    end
  end

  assign speed_o = speed_d;

endmodule

FILE: design/sdd_digit.sv
// multiplex slot counter, digit extraction and segment register
`timescale 1ns / 1ps

module sdd_digit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  refresh_i,
  input  logic [13:0]           speed_i,
  input  sdd_pkg::timer_status_t status_i,
  output sdd_pkg::slot_result_t result_o
);

  logic [2:0]  slot_q, slot_d, slot_inc;
  logic [7:0]  seg_q, seg_d;
  logic [27:0] prod_th;
  logic [26:0] prod_hu;
  logic [29:0] prod_te;
  logic [3:0]  q1000;
  logic [6:0]  q100;
  logic [9:0]  q10;
  logic [3:0]  dig_th, dig_hu, dig_te, dig_un;
  logic [6:0]  hu_full;
  logic [9:0]  te_full;
  logic [13:0] un_full;
  logic        wr;
  logic [7:0]  dsel;
  logic        latch;

  // constant reciprocals, exact for speeds up to 9999
  assign prod_th = 28'(speed_i) * 28'd8389;
  assign prod_hu = 27'(speed_i) * 27'd5243;
  assign prod_te = 30'(speed_i) * 30'd52429;
  assign q1000   = prod_th[26:23];
  assign q100    = prod_hu[25:19];
  assign q10     = prod_te[28:19];

  assign hu_full = q100 - ((7'(q1000) << 3) + (7'(q1000) << 1));
  assign te_full = q10 - ((10'(q100) << 3) + (10'(q100) << 1));
  assign un_full = speed_i - ((14'(q10) << 3) + (14'(q10) << 1));
  assign dig_th  = q1000;
  assign dig_hu  = hu_full[3:0];
  assign dig_te  = te_full[3:0];
  assign dig_un  = un_full[3:0];

  assign slot_inc = slot_q + 3'd1;

  always_comb begin
    slot_d = slot_q;
    seg_d  = seg_q;
    wr     = 1'b0;
    dsel   = sdd_pkg::DigNone;
    latch  = 1'b0;
    if (refresh_i) begin
      slot_d = slot_inc;
      unique case (slot_inc)
        sdd_pkg::SlotThousands: begin
          if (speed_i > 14'd999) begin
            seg_d = sdd_pkg::seg_pattern(dig_th);
            wr    = 1'b1;
            dsel  = sdd_pkg::DigThousands;
          end
        end
        sdd_pkg::SlotHundreds: begin
          if (speed_i > 14'd99) begin
            seg_d = sdd_pkg::seg_pattern(dig_hu);
            wr    = 1'b1;
            dsel  = sdd_pkg::DigHundreds;
          end
        end
        sdd_pkg::SlotTens: begin
          if (speed_i > 14'd9) begin
            seg_d = sdd_pkg::seg_pattern(dig_te);
            wr    = 1'b1;
            dsel  = sdd_pkg::DigTens;
          end
        end
        sdd_pkg::SlotUnits: begin
          seg_d = sdd_pkg::seg_pattern(dig_un);
          wr    = 1'b1;
          dsel  = sdd_pkg::DigUnits;
        end
        default: begin
          latch  = 1'b1;
          slot_d = sdd_pkg::SlotIdle;
        end
      endcase
      // screen off or dark blink phase hides the digit
      if (!latch && (status_i.screen_off || status_i.blink_dark)) begin
        dsel = sdd_pkg::DigNone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= sdd_pkg::SlotIdle;
      seg_q  <= '0;
    end else if (en_i) begin
      slot_q <= slot_d;
      seg_q  <= seg_d;
    end
  end

  assign result_o.segments         = seg_d;
  assign result_o.segments_written = wr;
  assign result_o.digit_select     = dsel;
  assign result_o.latch            = latch;

endmodule

FILE: design/speed_seven_segment_display_driver.sv
// top level of the multiplexed four-digit speed display driver
`timescale 1ns / 1ps

// Usage:
// - input channel (in_valid_i / in_stall_o) carries one transaction per status
//   sample: timer tick with elapsed milliseconds, refresh strobe, run / knob /
//   motor-stop flags, the three speeds and the ramp reset bit
// - every transaction with a tick advances the blink and idle timers; only a
//   refresh transaction produces an output transaction (out_valid_o / out_stall_i)
// - each refresh drives the next of five slots: thousands, hundreds, tens,
//   units, then a latch slot that restarts the slot counter
// - a transaction accepted into the input register is processed and leaves it
//   when it advances; a refresh result is then loaded into the result register
// - throughput: one transaction per cycle unless a refresh is blocked at the
//   result register; the state update (timers, ramp, slot counter) is one pass
//   of logic between the input register and the state and result registers
// - stall: the result register holds while out_stall_i is high; the input
//   register keeps a refresh transaction until the result register frees up,
//   and in_stall_o rises only while that register is blocked
// - reset clears timers, flags, shown speed, ramp mode, slot counter and the
//   segment register, and loads the configuration defaults
// - configuration writes are taken any time but are meant for an idle block
module speed_seven_segment_display_driver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        timer_tick_i,
  input  logic [9:0]  elapsed_ms_i,
  input  logic        refresh_i,
  input  logic        run_status_i,
  input  logic        knob_active_i,
  input  logic        motor_stop_i,
  input  logic [13:0] set_speed_i,
  input  logic [13:0] actual_speed_i,
  input  logic [13:0] control_speed_i,
  input  logic        ramp_reset_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  segments_o,
  output logic        segments_written_o,
  output logic [7:0]  digit_select_o,
  output logic        latch_o,
  output logic [13:0] shown_speed_o,
  output logic        screen_off_o,
  output logic        blink_dark_o
);

  // configuration registers
  logic [15:0] blink_on_q, blink_period_q;
  logic [19:0] screen_to_q;

  // input register stage
  logic        in_vld_q;
  logic        tick_q, refresh_q, run_q, knob_q, stop_q, rreset_q;
  logic [9:0]  elapsed_q;
  logic [13:0] set_q, act_q, ctl_q;

  // result register stage
  logic        out_vld_q;
  logic [7:0]  seg_out_q, dsel_out_q;
  logic        wr_out_q, latch_out_q, off_out_q, dark_out_q;
  logic [13:0] speed_out_q;

  logic                   in_accept;
  logic                   out_free;
  logic                   advance;
  logic [13:0]            speed;
  sdd_pkg::timer_status_t status;
  sdd_pkg::slot_result_t  slot_res;

  // a non-refresh transaction never waits on the output side
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!refresh_q || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_on_q     <= sdd_pkg::BlinkOnRst;
      blink_period_q <= sdd_pkg::BlinkPeriodRst;
      screen_to_q    <= sdd_pkg::ScreenToRst;
    end else if (cfg_we_i) begin
      unique case (sdd_pkg::cfg_idx_e'(cfg_idx_i))
        sdd_pkg::CFG_BLINK_ON:     blink_on_q     <= cfg_data_i[15:0];
        sdd_pkg::CFG_BLINK_PERIOD: blink_period_q <= cfg_data_i[15:0];
        sdd_pkg::CFG_SCREEN_TO:    screen_to_q    <= cfg_data_i;
        default: begin
          blink_on_q <= blink_on_q;
        end
      endcase
    end
  end

  // input register: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register: payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tick_q    <= timer_tick_i;
      elapsed_q <= elapsed_ms_i;
      refresh_q <= refresh_i;
      run_q     <= run_status_i;
      knob_q    <= knob_active_i;
      stop_q    <= motor_stop_i;
      set_q     <= set_speed_i;
      act_q     <= actual_speed_i;
      ctl_q     <= control_speed_i;
      rreset_q  <= ramp_reset_i;
    end
  end

  sdd_timers u_timers (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .tick_i         (tick_q),
    .elapsed_i      (elapsed_q),
    .run_i          (run_q),
    .knob_i         (knob_q),
    .blink_on_i     (blink_on_q),
    .blink_period_i (blink_period_q),
    .screen_to_i    (screen_to_q),
    .status_o       (status)
  );

  sdd_speed u_speed (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .refresh_i       (refresh_q),
    .run_i           (run_q),
    .knob_i          (knob_q),
    .stop_i          (stop_q),
    .ramp_reset_i    (rreset_q),
    .set_speed_i     (set_q),
    .actual_speed_i  (act_q),
    .control_speed_i (ctl_q),
    .speed_o         (speed)
  );

  sdd_digit u_digit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .refresh_i (refresh_q),
    .speed_i   (speed),
    .status_i  (status),
    .result_o  (slot_res)
  );

  // result register: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && refresh_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk_i) begin
    if (advance && refresh_q) begin
      seg_out_q   <= slot_res.segments;
      wr_out_q    <= slot_res.segments_written;
      dsel_out_q  <= slot_res.digit_select;
      latch_out_q <= slot_res.latch;
      speed_out_q <= speed;
      off_out_q   <= status.screen_off;
      dark_out_q  <= status.blink_dark;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign segments_o         = seg_out_q;
  assign segments_written_o = wr_out_q;
  assign digit_select_o     = dsel_out_q;
  assign latch_o            = latch_out_q;
  assign shown_speed_o      = speed_out_q;
  assign screen_off_o       = off_out_q;
  assign blink_dark_o       = dark_out_q;

`ifndef SYNTHESIS
  // the latch slot never selects a digit nor writes a pattern
  a_latch_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && latch_out_q |-> dsel_out_q == sdd_pkg::DigNone && !wr_out_q)
    else $error("latch slot selected a digit or wrote a pattern");

  // at most one digit enabled, and only with a fresh pattern
  a_dsel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $onehot0(dsel_out_q) &&
                  (dsel_out_q == sdd_pkg::DigNone || wr_out_q))
    else $error("digit select not one-hot or without a written pattern");

  // dark or screen-off results keep the digits blank
  a_blank_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (off_out_q || dark_out_q) |-> dsel_out_q == sdd_pkg::DigNone)
    else $error("digit selected while dark or screen off");

  // shown speed stays in display range
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> speed_out_q <= sdd_pkg::SpeedMax)
    else $error("shown speed above display range");

  // a stalled refresh leaves the input register loaded on the next cycle
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(refresh_q))
    else $error("blocked transaction left the input register");
`endif

endmodule
